@@ rtl/phc_pkg.sv @@
// Package for the PID heater controller: field widths, register indexes and constants.
package phc_pkg;

	localparam int TEMP_W     = 16;
	localparam int ERR_W      = TEMP_W + 1;
	localparam int DIFF_W     = ERR_W + 1;
	localparam int GAIN_W     = 16;
	localparam int LIMIT_W    = 31;
	localparam int DRIVE_W    = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;

	localparam int SUM_WIDTH_DEF      = 32;
	localparam int GAIN_FRAC_BITS_DEF = 8;

	localparam logic [DRIVE_W-1:0] DRIVE_FULL = 15'd25600;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN  = 2'd0,
		REG_INTEG_GAIN = 2'd1,
		REG_DERIV_GAIN = 2'd2,
		REG_SUM_LIMIT  = 2'd3
	} reg_idx_t;

	// Stage-load enables handed to the pipeline stages
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

@@ rtl/phc_integ.sv @@
// Error, derivative difference and saturating error sum (stage 2 and controller state).
module phc_integ import phc_pkg::*; #(
	parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic signed [TEMP_W-1:0]    setpoint_s1,
	input  logic signed [TEMP_W-1:0]    measured_s1,
	input  logic        [LIMIT_W-1:0]   sum_limit,
	output logic signed [ERR_W-1:0]     err_s2,
	output logic signed [DIFF_W-1:0]    diff_s2,
	output logic signed [SUM_WIDTH-1:0] sum_s2,
	output logic                        slim_s2
);

	localparam int AW = ((SUM_WIDTH > LIMIT_W + 1) ? SUM_WIDTH : LIMIT_W + 1) + 1;
	localparam logic signed [AW-1:0] CAP =
		{{(AW - SUM_WIDTH + 1){1'b0}}, {(SUM_WIDTH - 1){1'b1}}};

	logic signed [SUM_WIDTH-1:0] error_sum_q;
	logic signed [ERR_W-1:0]     prev_err_q;

	logic signed [ERR_W-1:0]  err;
	logic signed [DIFF_W-1:0] diff;
	logic signed [AW-1:0]     lim_ext;
	logic signed [AW-1:0]     bound;
	logic signed [AW-1:0]     raw;
	logic signed [AW-1:0]     sat;
	logic                     slim;

	always_comb begin
		err     = $signed({setpoint_s1[TEMP_W-1], setpoint_s1})
			- $signed({measured_s1[TEMP_W-1], measured_s1});
		diff    = $signed({err[ERR_W-1], err}) - $signed({prev_err_q[ERR_W-1], prev_err_q});
		lim_ext = $signed({{(AW - LIMIT_W){1'b0}}, sum_limit});
		bound   = (lim_ext > CAP) ? CAP : lim_ext;
		raw     = $signed({{(AW - SUM_WIDTH){error_sum_q[SUM_WIDTH-1]}}, error_sum_q})
			+ $signed({{(AW - ERR_W){err[ERR_W-1]}}, err});
		if (raw > bound) begin
			sat  = bound;
			slim = 1'b1;
		end else if (raw < -bound) begin
			sat  = -bound;
			slim = 1'b1;
		end else begin
			sat  = raw;
			slim = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q <= '0;
			prev_err_q  <= '0;
		end else if (en) begin
			error_sum_q <= sat[SUM_WIDTH-1:0];
			prev_err_q  <= err;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s2  <= err;
			diff_s2 <= diff;
			sum_s2  <= sat[SUM_WIDTH-1:0];
			slim_s2 <= slim;
		end
	end

endmodule

@@ rtl/phc_mult.sv @@
// Gain multipliers for the three terms (stage 3).
module phc_mult import phc_pkg::*; #(
	parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic        [GAIN_W-1:0]           prop_gain,
	input  logic        [GAIN_W-1:0]           integ_gain,
	input  logic        [GAIN_W-1:0]           deriv_gain,
	input  logic signed [ERR_W-1:0]            err_s2,
	input  logic signed [DIFF_W-1:0]           diff_s2,
	input  logic signed [SUM_WIDTH-1:0]        sum_s2,
	input  logic                               slim_s2,
	output logic signed [GAIN_W+ERR_W:0]       p_s3,
	output logic signed [GAIN_W+SUM_WIDTH:0]   i_s3,
	output logic signed [GAIN_W+DIFF_W:0]      d_s3,
	output logic                               slim_s3
);

	logic signed [GAIN_W+ERR_W:0]     p;
	logic signed [GAIN_W+SUM_WIDTH:0] i;
	logic signed [GAIN_W+DIFF_W:0]    d;

	always_comb begin
		p = $signed({1'b0, prop_gain}) * err_s2;
		i = $signed({1'b0, integ_gain}) * sum_s2;
		d = $signed({1'b0, deriv_gain}) * diff_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3    <= p;
			i_s3    <= i;
			d_s3    <= d;
			slim_s3 <= slim_s2;
		end
	end

endmodule

@@ rtl/phc_mix.sv @@
// Term scaling, summation and drive clamp (stage 4, result register).
module phc_mix import phc_pkg::*; #(
	parameter int SUM_WIDTH      = SUM_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [GAIN_W+ERR_W:0]     p_s3,
	input  logic signed [GAIN_W+SUM_WIDTH:0] i_s3,
	input  logic signed [GAIN_W+DIFF_W:0]    d_s3,
	input  logic                             slim_s3,
	output logic        [DRIVE_W-1:0]        drive_s4,
	output logic                             slim_s4,
	output logic                             dlim_s4
);

	localparam int PW = GAIN_W + ERR_W + 1;
	localparam int IW = GAIN_W + SUM_WIDTH + 1;
	localparam int DW = GAIN_W + DIFF_W + 1;
	localparam int TW = IW + 2;

	logic signed [TW-1:0] p_t;
	logic signed [TW-1:0] i_t;
	logic signed [TW-1:0] d_t;
	logic signed [TW-1:0] total;
	logic signed [TW-1:0] full;
	logic [DRIVE_W-1:0]   drive;
	logic                 dlim;

	always_comb begin
		p_t   = $signed({{(TW - PW){p_s3[PW-1]}}, p_s3}) >>> GAIN_FRAC_BITS;
		i_t   = $signed({{(TW - IW){i_s3[IW-1]}}, i_s3}) >>> GAIN_FRAC_BITS;
		d_t   = $signed({{(TW - DW){d_s3[DW-1]}}, d_s3}) >>> GAIN_FRAC_BITS;
		total = p_t + i_t + d_t;
		full  = $signed({{(TW - DRIVE_W){1'b0}}, DRIVE_FULL});
		if (total > full) begin
			drive = DRIVE_FULL;
			dlim  = 1'b1;
		end else if (total < 0) begin
			drive = '0;
			dlim  = 1'b1;
		end else begin
			drive = total[DRIVE_W-1:0];
			dlim  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			drive_s4 <= drive;
			slim_s4  <= slim_s3;
			dlim_s4  <= dlim;
		end
	end

endmodule

@@ rtl/pid_heater_controller.sv @@
// Top level of the PID heater controller: config registers, input register, pipeline control.
//
// Channel   Handshake            Payload
// in        in_valid/in_ready    setpoint, measured
// out       out_valid/out_ready  drive, sum_limited, drive_limited
// cfg       cfg_we               cfg_index, cfg_data
//
// One transaction per cycle sustained while out_ready stays high; a result is valid once it has
// passed the input register and the stage 2, stage 3 and stage 4 registers.
// The error-sum update (one add and bound compare in stage 2) sets the item rate.
// Reset clears the error sum, previous error, gains, bound and all valid bits.
// A stalled output holds its stage; earlier stages keep filling until full.
module pid_heater_controller import phc_pkg::*; #(
	parameter int SUM_WIDTH      = SUM_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [TEMP_W-1:0] setpoint,
	input  logic signed [TEMP_W-1:0] measured,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [DRIVE_W-1:0]       drive,
	output logic                     sum_limited,
	output logic                     drive_limited,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data
);

	logic [GAIN_W-1:0]  prop_gain_q;
	logic [GAIN_W-1:0]  integ_gain_q;
	logic [GAIN_W-1:0]  deriv_gain_q;
	logic [LIMIT_W-1:0] sum_limit_q;

	logic signed [TEMP_W-1:0] setpoint_s1;
	logic signed [TEMP_W-1:0] measured_s1;
	logic v1_q, v2_q, v3_q, v4_q;
	logic ld1, ld2, ld3, ld4;
	stage_en_t en;

	logic signed [ERR_W-1:0]            err_s2;
	logic signed [DIFF_W-1:0]           diff_s2;
	logic signed [SUM_WIDTH-1:0]        sum_s2;
	logic                               slim_s2;
	logic signed [GAIN_W+ERR_W:0]       p_s3;
	logic signed [GAIN_W+SUM_WIDTH:0]   i_s3;
	logic signed [GAIN_W+DIFF_W:0]      d_s3;
	logic                               slim_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= '0;
			integ_gain_q <= '0;
			deriv_gain_q <= '0;
			sum_limit_q  <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_PROP_GAIN:  prop_gain_q  <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN: integ_gain_q <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN: deriv_gain_q <= cfg_data[GAIN_W-1:0];
				REG_SUM_LIMIT:  sum_limit_q  <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ld4      = !v4_q || out_ready;
		ld3      = !v3_q || ld4;
		ld2      = !v2_q || ld3;
		ld1      = !v1_q || ld2;
		in_ready = ld1;
		en.s2    = v1_q && ld2;
		en.s3    = v2_q && ld3;
		en.s4    = v3_q && ld4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (ld1) v1_q <= in_valid;
			if (ld2) v2_q <= v1_q;
			if (ld3) v3_q <= v2_q;
			if (ld4) v4_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ld1) begin
			setpoint_s1 <= setpoint;
			measured_s1 <= measured;
		end
	end

	phc_integ #(
		.SUM_WIDTH(SUM_WIDTH)
	) u_integ (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en.s2),
		.setpoint_s1(setpoint_s1),
		.measured_s1(measured_s1),
		.sum_limit  (sum_limit_q),
		.err_s2     (err_s2),
		.diff_s2    (diff_s2),
		.sum_s2     (sum_s2),
		.slim_s2    (slim_s2)
	);

	phc_mult #(
		.SUM_WIDTH(SUM_WIDTH)
	) u_mult (
		.clk       (clk),
		.en        (en.s3),
		.prop_gain (prop_gain_q),
		.integ_gain(integ_gain_q),
		.deriv_gain(deriv_gain_q),
		.err_s2    (err_s2),
		.diff_s2   (diff_s2),
		.sum_s2    (sum_s2),
		.slim_s2   (slim_s2),
		.p_s3      (p_s3),
		.i_s3      (i_s3),
		.d_s3      (d_s3),
		.slim_s3   (slim_s3)
	);

	phc_mix #(
		.SUM_WIDTH     (SUM_WIDTH),
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_mix (
		.clk     (clk),
		.en      (en.s4),
		.p_s3    (p_s3),
		.i_s3    (i_s3),
		.d_s3    (d_s3),
		.slim_s3 (slim_s3),
		.drive_s4(drive),
		.slim_s4 (sum_limited),
		.dlim_s4 (drive_limited)
	);

	assign out_valid = v4_q;

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drive <= DRIVE_FULL)
		else $error("drive above full scale");

	a_clamp_edge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_limited |-> (drive == '0 || drive == DRIVE_FULL))
		else $error("clamped drive not at a rail");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v1_q && v2_q && v3_q && v4_q && !out_ready))
		else $error("input stalled with room in the pipeline");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !v3_q |=> !out_valid)
		else $error("result repeated after transaction");

endmodule

@@ bench/phc_checker.sv @@
// Checker for the PID heater controller: tracks config writes, predicts each result and compares.
module phc_checker import phc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic signed [TEMP_W-1:0] setpoint,
	input  logic signed [TEMP_W-1:0] measured,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic [DRIVE_W-1:0]       drive,
	input  logic                     sum_limited,
	input  logic                     drive_limited,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	output int                       fails,
	output int                       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint SUM_CAP    = (longint'(1) <<< (SUM_WIDTH_DEF - 1)) - 1;
	localparam longint FULL_SCALE = DRIVE_FULL;
	localparam int     FRAC       = GAIN_FRAC_BITS_DEF;

	typedef struct packed {
		logic [DRIVE_W-1:0] drive;
		logic               sum_lim;
		logic               drive_lim;
	} heater_result_t;

	logic [GAIN_W-1:0]  kp, ki, kd;
	logic [LIMIT_W-1:0] sum_bound;
	longint             err_sum;
	longint             err_prev;
	heater_result_t     drive_due[$];
	int                 bad_count;

	function automatic heater_result_t predict_drive(logic signed [TEMP_W-1:0] sp,
		logic signed [TEMP_W-1:0] ms);
		heater_result_t r;
		longint err, bound, acc, p_term, i_term, d_term, total;
		r = '0;
		err = longint'(sp) - longint'(ms);
		bound = longint'(sum_bound);
		if (bound > SUM_CAP)
			bound = SUM_CAP;
		acc = err_sum + err;
		if (acc > bound) begin
			acc = bound;
			r.sum_lim = 1'b1;
		end else if (acc < -bound) begin
			acc = -bound;
			r.sum_lim = 1'b1;
		end
		err_sum = acc;
		// arithmetic shift of a signed value rounds toward minus infinity
		p_term = (longint'(kp) * err) >>> FRAC;
		i_term = (longint'(ki) * acc) >>> FRAC;
		d_term = (longint'(kd) * (err - err_prev)) >>> FRAC;
		err_prev = err;
		total = p_term + i_term + d_term;
		if (total > FULL_SCALE) begin
			total = FULL_SCALE;
			r.drive_lim = 1'b1;
		end else if (total < 0) begin
			total = 0;
			r.drive_lim = 1'b1;
		end
		r.drive = total[DRIVE_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		heater_result_t want;
		if (!arst_n) begin
			kp = '0;
			ki = '0;
			kd = '0;
			sum_bound = '0;
			err_sum = 0;
			err_prev = 0;
			drive_due.delete();
			bad_count = 0;
			fails <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_PROP_GAIN:  kp = cfg_data[GAIN_W-1:0];
					REG_INTEG_GAIN: ki = cfg_data[GAIN_W-1:0];
					REG_DERIV_GAIN: kd = cfg_data[GAIN_W-1:0];
					REG_SUM_LIMIT:  sum_bound = cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				drive_due.push_back(predict_drive(setpoint, measured));
			if (out_valid && out_ready) begin
				if (drive_due.size() == 0) begin
					bad_count++;
					if (bad_count <= 10)
						$display("%t: unexpected transaction drive=%0d",
							$realtime, drive,
							" sum_lim=%0b drive_lim=%0b",
							sum_limited, drive_limited);
				end else begin
					want = drive_due.pop_front();
					if (drive !== want.drive || sum_limited !== want.sum_lim ||
						drive_limited !== want.drive_lim) begin
						bad_count++;
						if (bad_count <= 10)
							$display("%t: mismatch exp drive=%0d sum_lim=%0b drive_lim=%0b",
								$realtime, want.drive, want.sum_lim, want.drive_lim,
								", got drive=%0d sum_lim=%0b drive_lim=%0b",
								drive, sum_limited, drive_limited);
					end
				end
			end
			fails <= bad_count;
			pending <= drive_due.size();
		end
	end

endmodule

@@ bench/tb_pid_heater_controller.sv @@
// Testbench top for the PID heater controller: clock, reset, stimulus and verdict.
module tb_pid_heater_controller import phc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES = 40;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [TEMP_W-1:0] setpoint;
	logic signed [TEMP_W-1:0] measured;
	logic                     out_valid;
	logic                     out_ready;
	logic [DRIVE_W-1:0]       drive;
	logic                     sum_limited;
	logic                     drive_limited;
	logic                     cfg_we;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_data;
	int                       fails;
	int                       pending;
	logic                     quiet;
	logic                     hold_req;

	pid_heater_controller u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.setpoint      (setpoint),
		.measured      (measured),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.drive         (drive),
		.sum_limited   (sum_limited),
		.drive_limited (drive_limited),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	phc_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.setpoint      (setpoint),
		.measured      (measured),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.drive         (drive),
		.sum_limited   (sum_limited),
		.drive_limited (drive_limited),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fails         (fails),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// drain all outstanding results, then allow for the pipeline depth
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic send_sample(input logic signed [TEMP_W-1:0] sp,
		input logic signed [TEMP_W-1:0] ms);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		setpoint <= sp;
		measured <= ms;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return GAIN_W'($urandom);
			default: return GAIN_W'($urandom_range(0, 16'h0300));
		endcase
	endfunction

	// sink: random back-pressure, one long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	initial begin
		int                       base;
		logic signed [TEMP_W-1:0] sp;
		logic signed [TEMP_W-1:0] ms;
		logic [LIMIT_W-1:0]       lim;
		arst_n = 1'b0;
		in_valid = 1'b0;
		setpoint = '0;
		measured = '0;
		cfg_we = 1'b0;
		cfg_index = REG_PROP_GAIN;
		cfg_data = '0;
		quiet = 1'b0;
		hold_req = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// unity P, moderate I and D, small sum bound
		write_reg(REG_PROP_GAIN, 31'h100);
		write_reg(REG_INTEG_GAIN, 31'h10);
		write_reg(REG_DERIV_GAIN, 31'h80);
		write_reg(REG_SUM_LIMIT, 31'd1000);
		send_sample(16'sd160, 16'sd0);   // first sample: D sees the whole error
		send_sample(16'sh7FFF, -16'sh8000);
		send_sample(-16'sh8000, 16'sh7FFF);
		send_sample(16'sd0, 16'sd0);
		send_sample(16'sd100, 16'sd103);
		send_sample(-16'sd1, 16'sd0);
		send_sample(16'sh7FFF, 16'sh7FFF);
		send_sample(-16'sh8000, -16'sh8000);
		settle();

		// zero bound, full-scale I and D, odd P to show floor rounding
		write_reg(REG_PROP_GAIN, 31'd3);
		write_reg(REG_INTEG_GAIN, 31'hFFFF);
		write_reg(REG_DERIV_GAIN, 31'hFFFF);
		write_reg(REG_SUM_LIMIT, 31'd0);
		send_sample(16'sd1, 16'sd0);
		send_sample(16'sd0, 16'sd1);
		send_sample(16'sd0, 16'sd0);
		send_sample(-16'sd5, -16'sd5);
		send_sample(16'sd200, 16'sd0);
		settle();

		// widest bound, full P only
		write_reg(REG_PROP_GAIN, 31'hFFFF);
		write_reg(REG_INTEG_GAIN, 31'd0);
		write_reg(REG_DERIV_GAIN, 31'd0);
		write_reg(REG_SUM_LIMIT, 31'h7FFF_FFFF);
		send_sample(16'sh7FFF, -16'sh8000);
		send_sample(16'sh7FFF, -16'sh8000);
		send_sample(-16'sh8000, 16'sh7FFF);
		send_sample(16'sd10, 16'sd20);
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			quiet = (ph == 7);
			case ($urandom_range(0, 3))
				0: lim = '0;
				1: lim = '1;
				2: lim = LIMIT_W'($urandom_range(0, 30000));
				default: lim = LIMIT_W'($urandom);
			endcase
			write_reg(REG_PROP_GAIN, CFG_DATA_W'(pick_gain()));
			write_reg(REG_INTEG_GAIN, CFG_DATA_W'(pick_gain()));
			write_reg(REG_DERIV_GAIN, CFG_DATA_W'(pick_gain()));
			write_reg(REG_SUM_LIMIT, lim);
			for (int n = 0; n < 100; n++) begin
				if (ph == 1 && n == 20)
					hold_req = 1'b1;
				if ($urandom_range(0, 9) < 2) begin
					sp = TEMP_W'($urandom);
					ms = TEMP_W'($urandom);
				end else begin
					// measured temperature tracking near the setpoint
					base = $urandom_range(0, 8000) - 4000;
					sp = TEMP_W'(base);
					ms = TEMP_W'(base + $urandom_range(0, 128) - 64);
				end
				send_sample(sp, ms);
			end
			settle();
		end

		if (fails == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ pid_heater_controller.f @@
rtl/phc_pkg.sv
rtl/phc_integ.sv
rtl/phc_mult.sv
rtl/phc_mix.sv
rtl/pid_heater_controller.sv
bench/phc_checker.sv
bench/tb_pid_heater_controller.sv
